>>> src/snv_pkg.sv
// ----------------------------------------------------------------------------
// snv_pkg
// shared constants and edge functions for the surface nets cell vertex block
// ----------------------------------------------------------------------------
package snv_pkg;

    localparam int MAX_CELLS_PER_AXIS = 256;
    localparam int CFG_W   = 9;
    localparam int DIST_W  = 16;
    localparam int MAG_W   = 16;
    localparam int FRAC_W  = 13;
    localparam int SUM_W   = 17;
    localparam int CNT_W   = 24;
    localparam int COORD_W = 8;
    localparam int NUM_EDGES = 12;
    localparam logic [FRAC_W-1:0] ONE_Q12 = 13'd4096;

    // register indexes
    localparam logic [1:0] REG_CELLS_X = 2'd0;
    localparam logic [1:0] REG_CELLS_Y = 2'd1;
    localparam logic [1:0] REG_CELLS_Z = 2'd2;

    // corner at the low end of edge e
    function automatic logic [2:0] edge_a(input logic [3:0] e);
        case (e)
            4'd0:  edge_a = 3'd0;
            4'd1:  edge_a = 3'd2;
            4'd2:  edge_a = 3'd4;
            4'd3:  edge_a = 3'd6;
            4'd4:  edge_a = 3'd0;
            4'd5:  edge_a = 3'd1;
            4'd6:  edge_a = 3'd4;
            4'd7:  edge_a = 3'd5;
            4'd8:  edge_a = 3'd0;
            4'd9:  edge_a = 3'd1;
            4'd10: edge_a = 3'd2;
            4'd11: edge_a = 3'd3;
            default: edge_a = 3'd0;
        endcase
    endfunction

    // axis of edge e: 0 x, 1 y, 2 z
    function automatic logic [1:0] edge_axis(input logic [3:0] e);
        edge_axis = e[3] ? 2'd2 : (e[2] ? 2'd1 : 2'd0);
    endfunction

endpackage

>>> src/surface_nets_cell_vertex.sv
// ----------------------------------------------------------------------------
// surface_nets_cell_vertex
// naive surface nets vertex stage: one cell of corner distances in, one
// vertex record out, edge fractions and means from one shared divider
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      i_valid / o_ready         i_corner_0..7
// out       output     o_valid / i_ready         o_has_vertex .. o_last_cell
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// each division runs 17 steps of a radix-2 restoring divider, the single
// divider. a crossing edge costs a setup step and a division, any other edge
// the setup step, each of the three means a setup step and a division, then
// the output write. a cell with all corners on one side goes straight from
// the first edge to the output write. the next cell can be taken the cycle
// after the output item leaves, never while a cell is in work. reset is
// synchronous, clears position and count and sets each cells register to 64.
// ----------------------------------------------------------------------------
module surface_nets_cell_vertex
    import snv_pkg::*;
#(
    parameter int P_MAX_CELLS = MAX_CELLS_PER_AXIS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_corner_0,
    input  logic signed [15:0]  i_corner_1,
    input  logic signed [15:0]  i_corner_2,
    input  logic signed [15:0]  i_corner_3,
    input  logic signed [15:0]  i_corner_4,
    input  logic signed [15:0]  i_corner_5,
    input  logic signed [15:0]  i_corner_6,
    input  logic signed [15:0]  i_corner_7,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_has_vertex,
    output logic [23:0]         o_vertex_number,
    output logic [7:0]          o_cell_x,
    output logic [7:0]          o_cell_y,
    output logic [7:0]          o_cell_z,
    output logic [12:0]         o_offset_x,
    output logic [12:0]         o_offset_y,
    output logic [12:0]         o_offset_z,
    output logic                o_last_cell,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);

    localparam int POS_W = $clog2(P_MAX_CELLS);
    localparam int EFF_W = $clog2(P_MAX_CELLS + 1);
    localparam int QUO_W = 17;   // dividend width for both division kinds

    typedef enum logic [2:0] {
        S_IDLE, S_EDGE, S_DIV, S_MEAN, S_MDIV, S_OUT
    } t_state;

    t_state r_state;
    logic signed [DIST_W-1:0] r_val [8];
    logic [3:0]  r_edge;
    logic [1:0]  r_axis;
    logic [3:0]  r_ncross;
    logic [SUM_W-1:0] r_sum [3];
    logic [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [CNT_W-1:0] r_vcount;
    logic [CFG_W-1:0] r_cells_x, r_cells_y, r_cells_z;

    // shared restoring divider
    logic [QUO_W-1:0] r_quo;     // dividend shifting out, quotient shifting in
    logic [QUO_W:0]   r_rem;
    logic [QUO_W:0]   r_den;
    logic [4:0]       r_step;

    logic r_ovalid, r_has, r_last;
    logic [CNT_W-1:0] r_num;
    logic [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [FRAC_W-1:0]  r_off [3];

    // corner signs
    logic [7:0] ins;
    always_comb begin
        for (int c = 0; c < 8; c++) ins[c] = r_val[c][DIST_W-1];
    end

    // current edge
    logic [2:0] ea, eb;
    logic [1:0] eax;
    logic [MAG_W:0] ma, mb;
    always_comb begin
        ea  = edge_a(r_edge);
        eax = edge_axis(r_edge);
        eb  = ea | (3'd1 << eax);
        ma  = r_val[ea][DIST_W-1] ? (MAG_W+1)'(-{r_val[ea][DIST_W-1], r_val[ea]})
                                  : (MAG_W+1)'({1'b0, r_val[ea]});
        mb  = r_val[eb][DIST_W-1] ? (MAG_W+1)'(-{r_val[eb][DIST_W-1], r_val[eb]})
                                  : (MAG_W+1)'({1'b0, r_val[eb]});
    end

    // divider step
    logic [QUO_W:0] trial;
    logic           fits;
    always_comb begin
        trial = {r_rem[QUO_W-1:0], r_quo[QUO_W-1]};
        fits  = trial >= r_den;
    end

    // effective counts and end flags
    function automatic logic [EFF_W-1:0] eff(input logic [CFG_W-1:0] v);
        if (v == '0) eff = EFF_W'(1);
        else if (32'(v) > P_MAX_CELLS) eff = EFF_W'(P_MAX_CELLS);
        else eff = EFF_W'(v);
    endfunction

    logic end_x, end_y, end_z, last;
    always_comb begin
        end_x = (32'(r_pos_x) + 1) >= 32'(eff(r_cells_x));
        end_y = (32'(r_pos_y) + 1) >= 32'(eff(r_cells_y));
        end_z = (32'(r_pos_z) + 1) >= 32'(eff(r_cells_z));
        last  = end_x && end_y && end_z;
    end

    logic mixed;
    assign mixed    = (ins != 8'h00) && (ins != 8'hff);
    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;

    // sequencer, divider and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= '0;
            r_vcount  <= '0;
            r_cells_x <= CFG_W'(64);
            r_cells_y <= CFG_W'(64);
            r_cells_z <= CFG_W'(64);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CELLS_X: r_cells_x <= i_cfg_data;
                    REG_CELLS_Y: r_cells_y <= i_cfg_data;
                    REG_CELLS_Z: r_cells_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_val[0] <= i_corner_0;
                        r_val[1] <= i_corner_1;
                        r_val[2] <= i_corner_2;
                        r_val[3] <= i_corner_3;
                        r_val[4] <= i_corner_4;
                        r_val[5] <= i_corner_5;
                        r_val[6] <= i_corner_6;
                        r_val[7] <= i_corner_7;
                        r_edge   <= '0;
                        r_ncross <= '0;
                        for (int k = 0; k < 3; k++) r_sum[k] <= '0;
                        r_state  <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (!mixed) begin
                        r_state <= S_OUT;
                    end else if (ins[ea] != ins[eb]) begin
                        // fraction = ma*4096 / (ma+mb); the top bits of the
                        // dividend sit below the divisor and start as remainder
                        r_quo   <= QUO_W'({ma[4:0], 12'd0});
                        r_rem   <= (QUO_W+1)'(ma[MAG_W-1:5]);
                        r_den   <= (QUO_W+1)'(ma + mb);
                        r_step  <= '0;
                        r_state <= S_DIV;
                        // other axes take 4096 where corner a has the bit
                        for (int k = 0; k < 3; k++) begin
                            if (k != int'(eax) && ea[k])
                                r_sum[k] <= r_sum[k] + SUM_W'(ONE_Q12);
                        end
                        r_ncross <= r_ncross + 4'd1;
                    end else if (r_edge == 4'(NUM_EDGES-1)) begin
                        r_axis  <= '0;
                        r_state <= S_MEAN;
                    end else begin
                        r_edge <= r_edge + 4'd1;
                    end
                end
                S_DIV, S_MDIV: begin
                    r_rem  <= fits ? trial - r_den : trial;
                    r_quo  <= {r_quo[QUO_W-2:0], fits};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(QUO_W-1)) begin
                        if (r_state == S_DIV) begin
                            r_sum[eax] <= r_sum[eax] + SUM_W'({r_quo[QUO_W-2:0], fits});
                            if (r_edge == 4'(NUM_EDGES-1)) begin
                                r_axis  <= '0;
                                r_state <= S_MEAN;
                            end else begin
                                r_edge  <= r_edge + 4'd1;
                                r_state <= S_EDGE;
                            end
                        end else begin
                            r_off[r_axis] <= FRAC_W'({r_quo[QUO_W-2:0], fits});
                            if (r_axis == 2'd2) r_state <= S_OUT;
                            else begin
                                r_axis  <= r_axis + 2'd1;
                                r_state <= S_MEAN;
                            end
                        end
                    end
                end
                S_MEAN: begin
                    r_quo   <= QUO_W'(r_sum[r_axis]);
                    r_rem   <= '0;
                    r_den   <= (QUO_W+1)'(r_ncross);
                    r_step  <= '0;
                    r_state <= S_MDIV;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_has    <= mixed;
                    r_num    <= mixed ? r_vcount : '0;
                    if (!mixed) for (int k = 0; k < 3; k++) r_off[k] <= '0;
                    r_cx     <= COORD_W'(r_pos_x);
                    r_cy     <= COORD_W'(r_pos_y);
                    r_cz     <= COORD_W'(r_pos_z);
                    r_last   <= last;
                    if (last) begin
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_pos_z  <= '0;
                        r_vcount <= '0;
                    end else begin
                        if (mixed) r_vcount <= r_vcount + CNT_W'(1);
                        if (!end_x) r_pos_x <= r_pos_x + POS_W'(1);
                        else begin
                            r_pos_x <= '0;
                            if (!end_y) r_pos_y <= r_pos_y + POS_W'(1);
                            else begin
                                r_pos_y <= '0;
                                r_pos_z <= r_pos_z + POS_W'(1);
                            end
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_has_vertex    = r_has;
    assign o_vertex_number = r_num;
    assign o_cell_x        = r_cx;
    assign o_cell_y        = r_cy;
    assign o_cell_z        = r_cz;
    assign o_offset_x      = r_off[0];
    assign o_offset_y      = r_off[1];
    assign o_offset_z      = r_off[2];
    assign o_last_cell     = r_last;

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_off[0] <= ONE_Q12 && r_off[1] <= ONE_Q12 && r_off[2] <= ONE_Q12))
        else $error("offset above one");
    a_cross_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEAN) |-> (r_ncross != 4'd0 && r_ncross <= 4'd12))
        else $error("crossing count out of range");
    a_novtx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_has) |-> (r_num == '0)) else $error("number without vertex");

endmodule
